// ===== sv/sbb_pkg.sv =====
// Package with shared types, constants and tables of the separable box blur.
package sbb_pkg;

    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_W      = 16;
    localparam int DIM_W       = 9;
    localparam int IDX_W       = 8;
    localparam int RAD_W       = 5;
    localparam int WIN_W       = 10;
    localparam int SUM_W       = 14;
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam logic [DIM_W-1:0] MAX_DIM    = 9'd256;
    localparam logic [RAD_W-1:0] MAX_RADIUS = 5'd30;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    // Reciprocal of 2r+1 scaled by 2^20 and rounded up; the zero radius never filters.
    localparam logic [RECIP_W-1:0] RECIP [0:30] = '{
        19'd0,      19'd349526, 19'd209716, 19'd149797, 19'd116509, 19'd95326,
        19'd80660,  19'd69906,  19'd61681,  19'd55189,  19'd49933,  19'd45591,
        19'd41944,  19'd38837,  19'd36158,  19'd33826,  19'd31776,  19'd29960,
        19'd28340,  19'd26887,  19'd25576,  19'd24386,  19'd23302,  19'd22311,
        19'd21400,  19'd20561,  19'd19785,  19'd19066,  19'd18397,  19'd17773,
        19'd17190
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_LINE_START,
        ST_INIT,
        ST_DRAIN,
        ST_STEP_A,
        ST_STEP_B,
        ST_STEP_C
    } state_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [RAD_W-1:0] radius;
    } geom_t;

    typedef struct packed {
        logic load_wr;
        logic rd_issue;
        logic out_pixel;
        logic out_zero;
        logic set_valid;
        logic pass_start;
        logic pass_v;
        logic line_start;
        logic line_next;
        logic init_rd;
        logic step_a;
        logic step_b;
        logic step_c;
    } cmd_t;

    typedef struct packed {
        logic load_last;
        logic frame_valid;
        logic radius_zero;
        logic out_free;
        logic win_last;
        logic j_last;
        logic line_last;
        logic pass_v;
    } stat_t;

endpackage

// ===== sv/sbb_if.sv =====
// Handshake channel interfaces for input items and result items.
interface sbb_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] pixel_in;

    modport source (output valid, output opcode, output pixel_in, input ready);
    modport sink (input valid, input opcode, input pixel_in, output ready);
endinterface

interface sbb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_out;
    logic        last_pixel;
    logic        frame_ready;

    modport source (output valid, output pixel_out, output last_pixel, output frame_ready,
                    input ready);
    modport sink (input valid, input pixel_out, input last_pixel, input frame_ready,
                  output ready);
endinterface

// ===== sv/sbb_ctrl.sv =====
// Controller state machine that sequences loads, readout and the two filter passes.
module sbb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_opcode,
    output logic          in_ready,
    input  sbb_pkg::stat_t stat,
    output sbb_pkg::cmd_t  cmd
);
    import sbb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE) && stat.out_free;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_opcode == OP_LOAD)
                    begin
                        if (stat.load_last && !stat.radius_zero)
                        begin
                            state_next = ST_LINE_START;
                        end
                    end
                    else if (stat.frame_valid)
                    begin
                        state_next = ST_RD_WAIT;
                    end
                end
            end
            ST_RD_WAIT:    state_next = ST_IDLE;
            ST_LINE_START: state_next = ST_INIT;
            ST_INIT:
            begin
                if (stat.win_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:      state_next = ST_STEP_A;
            ST_STEP_A:     state_next = ST_STEP_B;
            ST_STEP_B:     state_next = ST_STEP_C;
            ST_STEP_C:
            begin
                if (!stat.j_last)
                begin
                    state_next = ST_STEP_A;
                end
                else if (stat.line_last && stat.pass_v)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_LINE_START;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_opcode == OP_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                        if (stat.load_last)
                        begin
                            cmd.set_valid  = stat.radius_zero;
                            cmd.pass_start = !stat.radius_zero;
                        end
                    end
                    else if (stat.frame_valid)
                    begin
                        cmd.rd_issue = 1'b1;
                    end
                    else
                    begin
                        cmd.out_zero = 1'b1;
                    end
                end
            end
            ST_RD_WAIT:    cmd.out_pixel  = 1'b1;
            ST_LINE_START: cmd.line_start = 1'b1;
            ST_INIT:       cmd.init_rd    = 1'b1;
            ST_DRAIN:      cmd = '0;
            ST_STEP_A:     cmd.step_a     = 1'b1;
            ST_STEP_B:     cmd.step_b     = 1'b1;
            ST_STEP_C:
            begin
                cmd.step_c = 1'b1;
                if (stat.j_last)
                begin
                    if (!stat.line_last)
                    begin
                        cmd.line_next = 1'b1;
                    end
                    else if (stat.pass_v)
                    begin
                        cmd.set_valid = 1'b1;
                    end
                    else
                    begin
                        cmd.pass_start = 1'b1;
                        cmd.pass_v     = 1'b1;
                    end
                end
            end
            default:       cmd = '0;
        endcase
    end

endmodule

// ===== sv/sbb_datapath.sv =====
// Datapath: frame stores, running window sums, reciprocal divide and output register.
module sbb_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sbb_pkg::geom_t          geom,
    input  sbb_pkg::cmd_t           cmd,
    output sbb_pkg::stat_t          stat,
    input  logic [31:0]             pixel_in,
    sbb_out_if.source               out_ch
);
    import sbb_pkg::*;

    logic [31:0] src_mem [STORE_DEPTH];
    logic [31:0] row_mem [STORE_DEPTH];
    logic [31:0] src_q_reg;
    logic [31:0] row_q_reg;

    logic [ADDR_W-1:0]       load_pos_reg;
    logic [ADDR_W-1:0]       read_pos_reg;
    logic                    valid_reg;
    logic                    last_pend_reg;
    logic                    pass_v_reg;
    logic [IDX_W-1:0]        line_reg;
    logic [IDX_W-1:0]        j_reg;
    logic signed [WIN_W-1:0] win_reg;
    logic                    acc_pend_reg;
    logic [SUM_W-1:0]        sums_reg [4];
    logic [31:0]             c1_reg;
    logic [PROD_W-1:0]       prod_reg [4];

    logic [31:0]             out_pixel_reg;
    logic                    out_last_reg;
    logic                    out_frame_reg;
    logic                    out_valid_reg;

    logic [ADDR_W:0]         total;
    logic [DIM_W-1:0]        len;
    logic [DIM_W-1:0]        lines;
    logic signed [WIN_W-1:0] j_s;
    logic signed [WIN_W-1:0] r_s;
    logic signed [WIN_W-1:0] ridx;
    logic [ADDR_W-1:0]       pass_raddr;
    logic [ADDR_W-1:0]       pass_waddr;
    logic [ADDR_W-1:0]       src_raddr;
    logic [31:0]             rdata;
    logic [31:0]             quot;

    function automatic logic [IDX_W-1:0] clamp_idx(logic signed [WIN_W-1:0] v,
                                                   logic [DIM_W-1:0] n);
        logic [DIM_W-1:0] last;
        logic [IDX_W-1:0] res;
        last = n - 9'd1;
        if (v < 0)
        begin
            res = '0;
        end
        else if (v > $signed({1'b0, last}))
        begin
            res = last[IDX_W-1:0];
        end
        else
        begin
            res = v[IDX_W-1:0];
        end
        return res;
    endfunction

    // Horizontal lines run along a row; vertical lines run down a column.
    function automatic logic [ADDR_W-1:0] pix_addr(logic pv, logic [IDX_W-1:0] line,
                                                   logic [IDX_W-1:0] p, logic [DIM_W-1:0] w);
        logic [ADDR_W:0] prod;
        if (pv)
        begin
            prod = 17'({9'd0, p} * {8'd0, w}) + 17'(line);
        end
        else
        begin
            prod = 17'({9'd0, line} * {8'd0, w}) + 17'(p);
        end
        return prod[ADDR_W-1:0];
    endfunction

    assign total = 17'({9'd0, geom.width} * {9'd0, geom.height});
    assign len   = pass_v_reg ? geom.height : geom.width;
    assign lines = pass_v_reg ? geom.width : geom.height;
    assign j_s   = $signed({2'b00, j_reg});
    assign r_s   = $signed({5'd0, geom.radius});

    always_comb
    begin
        priority if (cmd.step_a)
        begin
            ridx = j_s - r_s;
        end
        else if (cmd.step_b)
        begin
            ridx = j_s + r_s + 10'sd1;
        end
        else
        begin
            ridx = win_reg;
        end
    end

    assign pass_raddr = pix_addr(pass_v_reg, line_reg, clamp_idx(ridx, len), geom.width);
    assign pass_waddr = pix_addr(pass_v_reg, line_reg, j_reg, geom.width);
    assign src_raddr  = cmd.rd_issue ? read_pos_reg : pass_raddr;
    assign rdata      = pass_v_reg ? row_q_reg : src_q_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            quot[8*k +: 8] = prod_reg[k][RECIP_SHIFT +: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            src_mem[load_pos_reg] <= pixel_in;
        end
        else if (cmd.step_c && pass_v_reg)
        begin
            src_mem[pass_waddr] <= quot;
        end
        src_q_reg <= src_mem[src_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step_c && !pass_v_reg)
        begin
            row_mem[pass_waddr] <= quot;
        end
        row_q_reg <= row_mem[pass_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg  <= '0;
            read_pos_reg  <= '0;
            valid_reg     <= 1'b0;
            last_pend_reg <= 1'b0;
            pass_v_reg    <= 1'b0;
            line_reg      <= '0;
            j_reg         <= '0;
            win_reg       <= '0;
            acc_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_pend_reg <= cmd.init_rd;
            if (cmd.load_wr)
            begin
                valid_reg    <= 1'b0;
                read_pos_reg <= '0;
                load_pos_reg <= stat.load_last ? '0 : load_pos_reg + 16'd1;
            end
            if (cmd.rd_issue)
            begin
                last_pend_reg <= ({1'b0, read_pos_reg} + 17'd1 >= total);
                if ({1'b0, read_pos_reg} + 17'd1 >= total)
                begin
                    read_pos_reg <= '0;
                    valid_reg    <= 1'b0;
                end
                else
                begin
                    read_pos_reg <= read_pos_reg + 16'd1;
                end
            end
            if (cmd.set_valid)
            begin
                valid_reg <= 1'b1;
            end
            if (cmd.pass_start)
            begin
                pass_v_reg <= cmd.pass_v;
                line_reg   <= '0;
            end
            if (cmd.line_start)
            begin
                win_reg <= -r_s;
                j_reg   <= '0;
            end
            if (cmd.init_rd)
            begin
                win_reg <= win_reg + 10'sd1;
            end
            if (cmd.step_c)
            begin
                j_reg <= j_reg + 8'd1;
            end
            if (cmd.line_next)
            begin
                line_reg <= line_reg + 8'd1;
            end
            if (cmd.out_pixel || cmd.out_zero)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_pixel)
        begin
            out_pixel_reg <= src_q_reg;
            out_last_reg  <= last_pend_reg;
            out_frame_reg <= 1'b1;
        end
        else if (cmd.out_zero)
        begin
            out_pixel_reg <= '0;
            out_last_reg  <= 1'b0;
            out_frame_reg <= 1'b0;
        end
        if (cmd.step_b)
        begin
            c1_reg <= rdata;
        end
        for (int k = 0; k < 4; k++)
        begin
            if (cmd.line_start)
            begin
                sums_reg[k] <= '0;
            end
            else if (acc_pend_reg)
            begin
                sums_reg[k] <= sums_reg[k] + 14'(rdata[8*k +: 8]);
            end
            else if (cmd.step_c)
            begin
                sums_reg[k] <= sums_reg[k] + 14'(rdata[8*k +: 8]) - 14'(c1_reg[8*k +: 8]);
            end
            if (cmd.step_a)
            begin
                prod_reg[k] <= PROD_W'({19'd0, sums_reg[k]} * {14'd0, RECIP[geom.radius]});
            end
        end
    end

    assign stat.load_last   = ({1'b0, load_pos_reg} + 17'd1 >= total);
    assign stat.frame_valid = valid_reg;
    assign stat.radius_zero = (geom.radius == '0);
    assign stat.out_free    = !out_valid_reg || out_ch.ready;
    assign stat.win_last    = (win_reg == r_s);
    assign stat.j_last      = ({1'b0, j_reg} == len - 9'd1);
    assign stat.line_last   = ({1'b0, line_reg} == lines - 9'd1);
    assign stat.pass_v      = pass_v_reg;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.pixel_out   = out_pixel_reg;
    assign out_ch.last_pixel  = out_last_reg;
    assign out_ch.frame_ready = out_frame_reg;

endmodule

// ===== sv/separable_box_blur.sv =====
// Top level of the separable box blur: register port, controller and datapath.
// A load, and a read while no frame is available, are answered from the idle state; a read of the
// frame passes through a wait state, since the frame store has a registered read port;
// a read answers only once its earlier result has been taken. The load that completes the
// frame starts the filter, which runs over one shared read port per store; in each pass every
// line goes through line start, window fill and drain, then steps A, B and C for each pixel,
// and no item is accepted until both passes are done. A zero radius skips the filter.
// Frame width and height are clamped to 1..256 and the radius to 0..30.
module separable_box_blur (
    input  logic             clk,
    input  logic             rst_n,
    sbb_in_if.sink           in_ch,
    sbb_out_if.source        out_ch,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sbb_pkg::*;

    logic [8:0] width_reg;
    logic [8:0] height_reg;
    logic [5:0] radius_reg;
    logic       wr_en;
    geom_t      geom;
    cmd_t       cmd;
    stat_t      stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= MAX_DIM;
            height_reg <= MAX_DIM;
            radius_reg <= 6'd1;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_WIDTH:  width_reg  <= pwdata[8:0];
                REG_HEIGHT: height_reg <= pwdata[8:0];
                REG_RADIUS: radius_reg <= pwdata[5:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_RADIUS: prdata = 32'(radius_reg);
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        geom.width  = (width_reg == '0) ? 9'd1 : ((width_reg > MAX_DIM) ? MAX_DIM : width_reg);
        geom.height = (height_reg == '0) ? 9'd1
                                         : ((height_reg > MAX_DIM) ? MAX_DIM : height_reg);
        geom.radius = (radius_reg > 6'(MAX_RADIUS)) ? MAX_RADIUS : radius_reg[4:0];
    end

    sbb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_ready  (in_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sbb_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .geom     (geom),
        .cmd      (cmd),
        .stat     (stat),
        .pixel_in (in_ch.pixel_in),
        .out_ch   (out_ch)
    );

endmodule

// ===== sv/sbb_checker.sv =====
// Port-level checks of the separable box blur, bound to the top level.
module sbb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_opcode,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] pixel_out,
    input logic        last_pixel,
    input logic        frame_ready
);
    import sbb_pkg::*;

    // A read either shows a result in the next cycle or holds off the input.
    a_read_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_opcode == OP_READ) |=> (out_valid || !in_ready))
        else $error("read transfer not followed by a result or a stall");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_ready) |-> (pixel_out == '0 && !last_pixel))
        else $error("result without a frame is not all zero");

    a_last_framed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_pixel) |-> frame_ready)
        else $error("last pixel flagged without a frame");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pixel_out)))
        else $error("stalled result changed");

endmodule

bind separable_box_blur sbb_checker u_sbb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_opcode   (in_ch.opcode),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .pixel_out   (out_ch.pixel_out),
    .last_pixel  (out_ch.last_pixel),
    .frame_ready (out_ch.frame_ready)
);
